/* design/watchdog_timer_regs_defines.svh */
// Assertion macros used by wdt_core of the watchdog register block.
`ifndef WATCHDOG_TIMER_REGS_DEFINES_SVH
`define WATCHDOG_TIMER_REGS_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define WDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property that also holds during reset.
`define WDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WDT_ASSERT(label, prop, msg)
`define WDT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* design/wdt_pkg.sv */
// Types and constants of the watchdog register block.
`timescale 1ns / 1ps
package wdt_pkg;

  localparam int unsigned CountBitsDef = 32;

  localparam logic [31:0] KeyFeed = 32'h5A5A_5A5A;
  localparam logic [31:0] KeyLock = 32'h1ACC_E551;

  localparam int unsigned CtrlEnBit    = 0;
  localparam int unsigned CtrlIntEnBit = 1;
  localparam int unsigned StatToBit    = 0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } wdt_op_e;

  typedef enum logic [2:0] {
    REG_CTRL   = 3'd0,
    REG_RELOAD = 3'd1,
    REG_COUNT  = 3'd2,
    REG_STATUS = 3'd3,
    REG_KEY    = 3'd4
  } wdt_reg_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  word_index;
    logic [31:0] write_data;
  } wdt_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } wdt_rsp_t;

endpackage

/* design/wdt_core.sv */
// Watchdog register file, down counter and per-request update logic.
`timescale 1ns / 1ps
`include "watchdog_timer_regs_defines.svh"
module wdt_core #(
  parameter int unsigned CountBits = wdt_pkg::CountBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  wdt_pkg::wdt_req_t req_i,
  output wdt_pkg::wdt_rsp_t rsp_o
);
  import wdt_pkg::*;

  logic                 en_q, en_d;
  logic                 inten_q, inten_d;
  logic [31:0]          reload_q, reload_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 to_q, to_d;
  logic                 lock_q, lock_d;
  logic [CountBits-1:0] cnt_dec;
  logic                 ctrl_en;

  function automatic logic [CountBits-1:0] load_val(input logic [31:0] r);
    logic [CountBits-1:0] v;
    v = r[CountBits-1:0];
    return (v == '0) ? '1 : v;
  endfunction

  assign cnt_dec = (cnt_q != '0) ? cnt_q - CountBits'(1) : cnt_q;
  assign ctrl_en = req_i.write_data[CtrlEnBit] || (lock_q && en_q);

  always_comb begin
    en_d            = en_q;
    inten_d         = inten_q;
    reload_d        = reload_q;
    cnt_d           = cnt_q;
    to_d            = to_q;
    lock_d          = lock_q;
    rsp_o.read_data = '0;
    if (fire_i) begin
      case (req_i.op)
        OP_READ: begin
          case (req_i.word_index)
            REG_CTRL:   rsp_o.read_data = 32'({inten_q, en_q});
            REG_RELOAD: rsp_o.read_data = reload_q;
            REG_COUNT:  rsp_o.read_data = 32'(cnt_q);
            REG_STATUS: rsp_o.read_data = 32'(to_q);
            default:    rsp_o.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          case (req_i.word_index)
            REG_CTRL: begin
              en_d    = ctrl_en;
              inten_d = req_i.write_data[CtrlIntEnBit];
              if (ctrl_en) begin
                cnt_d = load_val(reload_q);
              end
            end
            REG_RELOAD: begin
              reload_d = req_i.write_data;
              if (en_q) begin
                cnt_d = load_val(req_i.write_data);
              end
            end
            REG_STATUS: begin
              if (req_i.write_data[StatToBit]) begin
                to_d = 1'b0;
              end
            end
            REG_KEY: begin
              if (req_i.write_data == KeyFeed) begin
                cnt_d = load_val(reload_q);
                en_d  = 1'b1;
              end else if (req_i.write_data == KeyLock) begin
                lock_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (en_q) begin
            cnt_d = cnt_dec;
            if (cnt_dec == '0) begin
              to_d = 1'b1;
              en_d = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    rsp_o.irq_level = to_d & inten_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      inten_q  <= 1'b0;
      reload_q <= '1;
      cnt_q    <= '1;
      to_q     <= 1'b0;
      lock_q   <= 1'b0;
    end else begin
      en_q     <= en_d;
      inten_q  <= inten_d;
      reload_q <= reload_d;
      cnt_q    <= cnt_d;
      to_q     <= to_d;
      lock_q   <= lock_d;
    end
  end

  `WDT_ASSERT(a_timeout_stops, $rose(to_q) |-> !en_q, "timeout set with enable still on")
  `WDT_ASSERT(a_enable_reloads, $rose(en_q) |-> cnt_q != '0, "enable without counter reload")
  `WDT_ASSERT(a_lock_sticky, !$fell(lock_q), "lock bit cleared without reset")
  `WDT_ASSERT(a_locked_clear, lock_q && $past(lock_q) && $fell(en_q) |-> $past(fire_i) && $past(req_i.op) == OP_TICK, "enable cleared by software while locked")

endmodule

/* design/watchdog_timer_regs.sv */
// Top level of the watchdog register block: request and result registers.
`timescale 1ns / 1ps
// Usage:
// - Request channel in_valid_i / in_stall_o / in_req_i carries one bus read,
//   one bus write or one counter tick. Accepted at a clock edge with valid
//   high and stall low.
// - Result channel out_valid_o / out_stall_i / out_rsp_o returns one result
//   per request, in order: read data (zero for writes, ticks, the key word and
//   unused words) and the interrupt level after the request.
// - Order: an accepted request waits in the request register, is executed against
//   the registers as it moves on, and its result is held in the result register.
// - Throughput: one request per cycle while the receiver does not stall; the register
//   update and the counter decrement are both combinational between request and result register.
// - While the receiver stalls, the result holds and one further request waits
//   in the request register; after that in_stall_o is raised.
// - Reset: watchdog disabled, interrupt disabled, unlocked, no timeout,
//   reload and count all ones; both channel registers empty.
module watchdog_timer_regs #(
  parameter int unsigned CountBits = wdt_pkg::CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wdt_pkg::wdt_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wdt_pkg::wdt_rsp_t out_rsp_o
);
  import wdt_pkg::*;

  logic     in_valid_q;
  wdt_req_t in_req_q;
  logic     out_valid_q;
  wdt_rsp_t out_rsp_q;
  wdt_rsp_t core_rsp;
  logic     advance;
  logic     fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  wdt_core #(
    .CountBits(CountBits)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (in_req_q),
    .rsp_o (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* tb/sv/tb_watchdog_timer_regs.sv */
// Self-checking testbench of the watchdog register block: predictor, scoreboard, random requests.
`timescale 1ns / 1ps

module tb_watchdog_timer_regs;
  import wdt_pkg::*;

  localparam logic [31:0] CountMask = 32'hFFFF_FFFF >> (32 - CountBitsDef);
  localparam logic [1:0]  OpNone     = 2'd3;
  localparam logic [2:0]  RegSpareLo = 3'd5;
  localparam logic [2:0]  RegSpareHi = 3'd7;

  class wdt_scoreboard;
    bit          run_en;
    bit          irq_en;
    bit          timed_out;
    bit          locked;
    logic [31:0] reload;
    logic [31:0] count;
    wdt_rsp_t    expected_q[$];
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_expiries;
    int unsigned n_held;

    function new();
      run_en     = 1'b0;
      irq_en     = 1'b0;
      timed_out  = 1'b0;
      locked     = 1'b0;
      reload     = '1;
      count      = CountMask;
      n_checked  = 0;
      n_errors   = 0;
      n_expiries = 0;
      n_held     = 0;
    endfunction

    function void load_count();
      count = ((reload & CountMask) != '0) ? (reload & CountMask) : CountMask;
    endfunction

    function void note_request(wdt_req_t req);
      wdt_rsp_t rsp;
      bit       en_req;
      rsp.read_data = '0;
      case (req.op)
        OP_READ: begin
          case (req.word_index)
            REG_CTRL:   rsp.read_data = {30'd0, irq_en, run_en};
            REG_RELOAD: rsp.read_data = reload;
            REG_COUNT:  rsp.read_data = count;
            REG_STATUS: rsp.read_data = {31'd0, timed_out};
            default:    rsp.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          case (req.word_index)
            REG_CTRL: begin
              en_req = req.write_data[CtrlEnBit];
              if (locked && run_en && !en_req) begin
                en_req = 1'b1;
                n_held++;
              end
              run_en = en_req;
              irq_en = req.write_data[CtrlIntEnBit];
              if (run_en) load_count();
            end
            REG_RELOAD: begin
              reload = req.write_data;
              if (run_en) load_count();
            end
            REG_STATUS: begin
              if (req.write_data[StatToBit]) timed_out = 1'b0;
            end
            REG_KEY: begin
              if (req.write_data == KeyFeed) begin
                load_count();
                run_en = 1'b1;
              end else if (req.write_data == KeyLock) begin
                locked = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (run_en) begin
            if (count != '0) count--;
            if (count == '0) begin
              timed_out = 1'b1;
              run_en    = 1'b0;
              n_expiries++;
            end
          end
        end
        default: ;
      endcase
      rsp.irq_level = timed_out & irq_en;
      expected_q.push_back(rsp);
    endfunction

    function void check_result(wdt_rsp_t got);
      wdt_rsp_t want;
      bit       bad;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: result with no request pending: read_data=%h irq_level=%b",
                   got.read_data, got.irq_level);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      bad = (got.read_data !== want.read_data) || (got.irq_level !== want.irq_level);
      if (bad) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: result %0d: read_data exp %h got %h, irq_level exp %b got %b",
                   n_checked, want.read_data, got.read_data, want.irq_level, got.irq_level);
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     out_stall_i = 1'b0;
  wdt_req_t in_req_i    = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  wdt_rsp_t out_rsp_o;
  bit       calm        = 1'b0;

  wdt_scoreboard sb;

  watchdog_timer_regs #(
    .CountBits(CountBitsDef)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
  end

  function automatic wdt_req_t make_req(logic [1:0] op, logic [2:0] idx, logic [31:0] data);
    wdt_req_t req;
    req.op         = op;
    req.word_index = idx;
    req.write_data = data;
    return req;
  endfunction

  function automatic wdt_req_t rand_request(bit lock_ok);
    int unsigned r;
    logic [31:0] d;
    logic [31:0] rl;
    wdt_req_t    req;
    r   = $urandom_range(99);
    d   = $urandom;
    req = make_req(OP_TICK, 3'($urandom_range(7)), d);
    if (r < 36) begin
      req = make_req(OP_TICK, 3'($urandom_range(7)), d);
    end else if (r < 46) begin
      req = make_req(OP_READ, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : REG_COUNT, d);
    end else if (r < 56) begin
      rl = ($urandom_range(9) == 0) ? d :
           ($urandom_range(15) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
      req = make_req(OP_WRITE, REG_RELOAD, rl);
    end else if (r < 64) begin
      d[CtrlEnBit] = ($urandom_range(3) != 0);
      req = make_req(OP_WRITE, REG_CTRL, d);
    end else if (r < 69) begin
      req = make_req(OP_WRITE, REG_STATUS, d);
    end else if (r < 76) begin
      req = make_req(OP_WRITE, REG_KEY, KeyFeed);
    end else if (r < 79) begin
      req = make_req(OP_WRITE, REG_KEY, d);
    end else if (r < 82) begin
      req = make_req(OpNone, 3'($urandom_range(7)), d);
    end else if (r < 86) begin
      req = make_req(OP_WRITE,
                     $urandom_range(1) ? REG_COUNT : 3'($urandom_range(RegSpareLo, RegSpareHi)),
                     d);
    end else if (r < 88 && lock_ok) begin
      req = make_req(OP_WRITE, REG_KEY, KeyLock);
    end
    return req;
  endfunction

  task automatic send(wdt_req_t req);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, then enable with zero reload and a short expiry
    send(make_req(OP_READ, REG_CTRL, '0));
    send(make_req(OP_READ, REG_RELOAD, '1));
    send(make_req(OP_READ, REG_COUNT, '0));
    send(make_req(OP_READ, REG_STATUS, '0));
    send(make_req(OP_READ, REG_KEY, '0));
    send(make_req(OP_READ, RegSpareHi, '1));
    send(make_req(OP_TICK, REG_CTRL, '1));
    send(make_req(OP_WRITE, REG_RELOAD, 32'd0));
    send(make_req(OP_WRITE, REG_CTRL, 32'h0000_0003));
    send(make_req(OP_READ, REG_COUNT, '0));
    send(make_req(OP_WRITE, REG_RELOAD, 32'd2));
    send(make_req(OP_TICK, REG_CTRL, '0));
    send(make_req(OP_TICK, REG_CTRL, '0));
    send(make_req(OP_READ, REG_STATUS, '0));
    send(make_req(OP_READ, REG_CTRL, '0));
    send(make_req(OP_WRITE, REG_STATUS, 32'hFFFF_FFFE));
    send(make_req(OP_WRITE, REG_STATUS, '1));
    send(make_req(OP_WRITE, REG_KEY, 32'h1234_5678));
    send(make_req(OP_WRITE, REG_KEY, KeyFeed));
    send(make_req(OP_WRITE, REG_CTRL, 32'hFFFF_FFFC));
    send(make_req(OpNone, REG_CTRL, '1));
    send(make_req(OP_WRITE, REG_COUNT, 32'hDEAD_BEEF));
    send(make_req(OP_WRITE, RegSpareLo, '1));
    send(make_req(OP_WRITE, REG_RELOAD, '1));
    send(make_req(OP_READ, REG_RELOAD, '0));

    for (int i = 0; i < 1250; i++) begin
      calm <= (i >= 500 && i < 800);
      send(rand_request(1'b0));
    end
    calm <= 1'b0;
    drain();

    // locked phase: clearing enable must be refused from here on
    send(make_req(OP_WRITE, REG_KEY, KeyLock));
    send(make_req(OP_WRITE, REG_RELOAD, 32'd5));
    send(make_req(OP_WRITE, REG_CTRL, 32'h0000_0001));
    send(make_req(OP_WRITE, REG_CTRL, 32'h0000_0000));
    send(make_req(OP_WRITE, REG_CTRL, 32'h0000_0002));
    send(make_req(OP_READ, REG_CTRL, '0));

    for (int i = 0; i < 600; i++) send(rand_request(1'b1));
    drain();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d results with %0d counter expiries and %0d lock-held enables,",
             sb.n_checked, sb.n_expiries, sb.n_held);
    $display("under random request gaps and result stalls, unlocked and then locked.");
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/wdt_pkg.sv
design/wdt_core.sv
design/watchdog_timer_regs.sv
tb/sv/tb_watchdog_timer_regs.sv
